>>> rtl/psrq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psrq_pkg
// Shared types and constants of the packet slot ring queue.
// ----------------------------------------------------------------------------
package psrq_pkg;

    localparam int QUEUE_SLOTS_DEF = 16;
    localparam int SLOT_BYTES_DEF  = 64;

    localparam int BYTE_W       = 8;
    localparam int STORED_LEN_W = 7;
    localparam int PKT_CNT_W    = 4;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_TRUNC = 2'd3
    } t_status;

    typedef struct packed {
        t_status                  status;
        logic [BYTE_W-1:0]        read_byte;
        logic                     read_last;
        logic [STORED_LEN_W-1:0]  stored_length;
        logic [PKT_CNT_W-1:0]     packets_queued;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/psrq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psrq_in_if / psrq_out_if
// Valid/ready channels carrying queue commands in and per-command results out.
// ----------------------------------------------------------------------------
interface psrq_in_if;
    import psrq_pkg::*;

    logic              valid;
    logic              ready;
    t_cmd              command;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, command, data_byte, last_byte, input ready);
    modport sink   (input valid, command, data_byte, last_byte, output ready);
endinterface

interface psrq_out_if;
    import psrq_pkg::*;

    logic                    valid;
    logic                    ready;
    t_status                 status;
    logic [BYTE_W-1:0]       read_byte;
    logic                    read_last;
    logic [STORED_LEN_W-1:0] stored_length;
    logic [PKT_CNT_W-1:0]    packets_queued;

    modport source (output valid, status, read_byte, read_last, stored_length,
                    packets_queued, input ready);
    modport sink   (input valid, status, read_byte, read_last, stored_length,
                    packets_queued, output ready);
endinterface
`default_nettype wire

>>> rtl/psrq_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psrq_store
// Slot byte memory and slot length table, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
module psrq_store #(
    parameter int   QUEUE_SLOTS = psrq_pkg::QUEUE_SLOTS_DEF,
    parameter int   SLOT_BYTES  = psrq_pkg::SLOT_BYTES_DEF,
    localparam int  SLOT_W      = $clog2(QUEUE_SLOTS),
    localparam int  LEN_W       = $clog2(SLOT_BYTES + 1),
    localparam int  DEPTH       = QUEUE_SLOTS * SLOT_BYTES,
    localparam int  ADDR_W      = $clog2(DEPTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rd_en,
    input  wire logic [ADDR_W-1:0]             i_byte_raddr,
    input  wire logic [SLOT_W-1:0]             i_len_raddr,
    output logic      [psrq_pkg::BYTE_W-1:0]   o_byte_rdata,
    output logic      [LEN_W-1:0]              o_len_rdata,
    input  wire logic                          i_byte_we,
    input  wire logic [ADDR_W-1:0]             i_byte_waddr,
    input  wire logic [psrq_pkg::BYTE_W-1:0]   i_byte_wdata,
    input  wire logic                          i_len_we,
    input  wire logic [SLOT_W-1:0]             i_len_waddr,
    input  wire logic [LEN_W-1:0]              i_len_wdata
);
    import psrq_pkg::*;

    logic [BYTE_W-1:0] mem_bytes [DEPTH];
    logic [LEN_W-1:0]  mem_len   [QUEUE_SLOTS];

    logic [BYTE_W-1:0] r_byte_rdata;
    logic [LEN_W-1:0]  r_len_rdata;

    always_ff @(posedge i_clk) begin
        if (i_byte_we) begin
            mem_bytes[i_byte_waddr] <= i_byte_wdata;
        end
        if (i_len_we) begin
            mem_len[i_len_waddr] <= i_len_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byte_rdata <= mem_bytes[i_byte_raddr];
            r_len_rdata  <= mem_len[i_len_raddr];
        end
    end

    assign o_byte_rdata = r_byte_rdata;
    assign o_len_rdata  = r_len_rdata;

endmodule
`default_nettype wire

>>> rtl/psrq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psrq_ctrl
// Command sequencer: issues the slot read, then updates head/tail/offsets,
// writes the byte and committed length, and forms the result.
// ----------------------------------------------------------------------------
module psrq_ctrl #(
    parameter int   QUEUE_SLOTS = psrq_pkg::QUEUE_SLOTS_DEF,
    parameter int   SLOT_BYTES  = psrq_pkg::SLOT_BYTES_DEF,
    localparam int  SLOT_W      = $clog2(QUEUE_SLOTS),
    localparam int  LEN_W       = $clog2(SLOT_BYTES + 1),
    localparam int  ADDR_W      = $clog2(QUEUE_SLOTS * SLOT_BYTES)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    psrq_in_if.sink                            i_req,
    input  wire logic                          i_skid_busy,
    output logic                               o_res_valid,
    output psrq_pkg::t_result                  o_res,
    output logic                               o_rd_en,
    output logic      [ADDR_W-1:0]             o_byte_raddr,
    output logic      [SLOT_W-1:0]             o_len_raddr,
    input  wire logic [psrq_pkg::BYTE_W-1:0]   i_byte_rdata,
    input  wire logic [LEN_W-1:0]              i_len_rdata,
    output logic                               o_byte_we,
    output logic      [ADDR_W-1:0]             o_byte_waddr,
    output logic      [psrq_pkg::BYTE_W-1:0]   o_byte_wdata,
    output logic                               o_len_we,
    output logic      [SLOT_W-1:0]             o_len_waddr,
    output logic      [LEN_W-1:0]              o_len_wdata
);
    import psrq_pkg::*;

    localparam int OFF_W = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int CMP_W = LEN_W + 1;
    localparam int CNT_W = SLOT_W + 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state             r_state,   n_state;
    logic [SLOT_W-1:0]  r_head,    n_head;
    logic [SLOT_W-1:0]  r_tail,    n_tail;
    logic [LEN_W-1:0]   r_wr_off,  n_wr_off;
    logic [OFF_W-1:0]   r_rd_off,  n_rd_off;
    logic               r_dropping, n_dropping;
    t_cmd               r_cmd,     n_cmd;
    logic [BYTE_W-1:0]  r_data,    n_data;
    logic               r_last,    n_last;

    logic               accept;
    logic               first;
    logic               full;
    logic               drop;
    logic               room;
    logic [LEN_W-1:0]   wr_inc;
    logic               empty;
    logic               rd_end;
    logic [CNT_W-1:0]   cnt;

    function automatic logic [SLOT_W-1:0] f_next(input logic [SLOT_W-1:0] idx);
        f_next = (idx == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign i_req.ready = (r_state == S_IDLE) && !i_skid_busy;
    assign accept      = i_req.valid && i_req.ready;

    // head and read offset do not move between the read and its use
    assign o_rd_en      = accept;
    assign o_byte_raddr = ADDR_W'(r_head) * ADDR_W'(SLOT_BYTES) + ADDR_W'(r_rd_off);
    assign o_len_raddr  = r_head;

    assign first  = (r_wr_off == '0) && !r_dropping;
    assign full   = (f_next(r_tail) == r_head);
    assign drop   = r_dropping || (first && full);
    assign room   = (r_wr_off < LEN_W'(SLOT_BYTES));
    assign wr_inc = room ? r_wr_off + 1'b1 : r_wr_off;
    assign empty  = (r_head == r_tail);
    assign rd_end = (CMP_W'(r_rd_off) + 1'b1) >= CMP_W'(i_len_rdata);

    assign o_byte_waddr = ADDR_W'(r_tail) * ADDR_W'(SLOT_BYTES) + ADDR_W'(r_wr_off);
    assign o_byte_wdata = r_data;
    assign o_len_waddr  = r_tail;
    assign o_len_wdata  = wr_inc;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_wr_off   = r_wr_off;
        n_rd_off   = r_rd_off;
        n_dropping = r_dropping;
        n_cmd      = r_cmd;
        n_data     = r_data;
        n_last     = r_last;
        o_byte_we  = 1'b0;
        o_len_we   = 1'b0;

        o_res.status         = ST_OK;
        o_res.read_byte      = '0;
        o_res.read_last      = 1'b0;
        o_res.stored_length  = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                    n_cmd   = i_req.command;
                    n_data  = i_req.data_byte;
                    n_last  = i_req.last_byte;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (r_cmd == CMD_ENQ) begin
                    if (drop) begin
                        // whole packet discarded once the first byte found no room
                        o_res.status = ST_FULL;
                        n_dropping   = !r_last;
                    end else begin
                        if (room) begin
                            o_byte_we = 1'b1;
                        end else begin
                            o_res.status = ST_TRUNC;
                        end
                        n_wr_off = wr_inc;
                        if (r_last) begin
                            o_len_we            = 1'b1;
                            o_res.stored_length = STORED_LEN_W'(wr_inc);
                            n_tail              = f_next(r_tail);
                            n_wr_off            = '0;
                        end
                    end
                end else begin
                    if (empty) begin
                        o_res.status = ST_EMPTY;
                    end else begin
                        o_res.read_byte     = i_byte_rdata;
                        o_res.stored_length = STORED_LEN_W'(i_len_rdata);
                        if (rd_end) begin
                            o_res.read_last = 1'b1;
                            n_rd_off        = '0;
                            n_head          = f_next(r_head);
                        end else begin
                            n_rd_off = r_rd_off + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_tail >= n_head) begin
            cnt = CNT_W'(n_tail) - CNT_W'(n_head);
        end else begin
            cnt = CNT_W'(n_tail) + CNT_W'(QUEUE_SLOTS) - CNT_W'(n_head);
        end
        o_res.packets_queued = PKT_CNT_W'(cnt);
    end

    assign o_res_valid = (r_state == S_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_wr_off   <= '0;
            r_rd_off   <= '0;
            r_dropping <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_wr_off   <= n_wr_off;
            r_rd_off   <= n_rd_off;
            r_dropping <= n_dropping;
        end
        r_cmd  <= n_cmd;
        r_data <= n_data;
        r_last <= n_last;
    end

`ifndef SYNTHESIS
    a_wr_off_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_off <= LEN_W'(SLOT_BYTES))
        else $error("write offset past slot size");

    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail != $past(r_tail)) |-> (r_tail != r_head))
        else $error("tail advanced onto head");

    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_cmd == CMD_DEQ && r_head == r_tail)
        |=> ($stable(r_head) && $stable(r_rd_off)))
        else $error("read state moved on empty queue");

    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte_we |-> (r_state == S_EXEC && r_cmd == CMD_ENQ && !r_dropping))
        else $error("byte write outside an accepted enqueue");
`endif

endmodule
`default_nettype wire

>>> rtl/psrq_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psrq_out_buf
// Result output register with a skid entry, so a stalled sink does not lose
// a result in flight.
// ----------------------------------------------------------------------------
module psrq_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_res_valid,
    input  wire psrq_pkg::t_result  i_res,
    output logic                    o_skid_busy,
    psrq_out_if.source              o_rsp
);
    import psrq_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_res_valid;
            r_skid_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_skid_busy          = r_skid_valid;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.read_byte      = r_out.read_byte;
    assign o_rsp.read_last      = r_out.read_last;
    assign o_rsp.stored_length  = r_out.stored_length;
    assign o_rsp.packets_queued = r_out.packets_queued;

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !r_skid_valid)
        else $error("result arrived with skid entry occupied");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && o_rsp.ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved on transfer");
`endif

endmodule
`default_nettype wire

>>> rtl/packet_slot_ring_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packet_slot_ring_queue
// Ring of fixed-size packet slots: byte-wide enqueue with drop-on-full and
// truncation, byte-wide dequeue with end-of-packet marking.
// ----------------------------------------------------------------------------
// Each command has a read step and an update step: the cycle it is
// transferred in issues the registered read of the slot byte memory and
// length table at the head, and the next cycle updates head, tail and
// offsets, writes the byte and the committed length, and loads the result.
// A new command is taken only once that update is done. A result register
// with one skid entry sits on the output, so a command is taken while the
// previous result waits for its transfer, though not while the skid entry
// is occupied. Slot storage holds no reset state; the block is ready right
// after reset with no clearing pass. One slot is always kept free, so at
// most QUEUE_SLOTS-1 packets are queued; the queued count and stored length fields report their low bits.
// ----------------------------------------------------------------------------
module packet_slot_ring_queue #(
    parameter int QUEUE_SLOTS = psrq_pkg::QUEUE_SLOTS_DEF,
    parameter int SLOT_BYTES  = psrq_pkg::SLOT_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    psrq_in_if.sink    i_req,
    psrq_out_if.source o_rsp
);
    import psrq_pkg::*;

    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
    localparam int ADDR_W = $clog2(QUEUE_SLOTS * SLOT_BYTES);

    logic               skid_busy;
    logic               res_valid;
    t_result            res;
    logic               rd_en;
    logic [ADDR_W-1:0]  byte_raddr;
    logic [SLOT_W-1:0]  len_raddr;
    logic [BYTE_W-1:0]  byte_rdata;
    logic [LEN_W-1:0]   len_rdata;
    logic               byte_we;
    logic [ADDR_W-1:0]  byte_waddr;
    logic [BYTE_W-1:0]  byte_wdata;
    logic               len_we;
    logic [SLOT_W-1:0]  len_waddr;
    logic [LEN_W-1:0]   len_wdata;

    psrq_ctrl #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .SLOT_BYTES  (SLOT_BYTES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_skid_busy  (skid_busy),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_rd_en      (rd_en),
        .o_byte_raddr (byte_raddr),
        .o_len_raddr  (len_raddr),
        .i_byte_rdata (byte_rdata),
        .i_len_rdata  (len_rdata),
        .o_byte_we    (byte_we),
        .o_byte_waddr (byte_waddr),
        .o_byte_wdata (byte_wdata),
        .o_len_we     (len_we),
        .o_len_waddr  (len_waddr),
        .o_len_wdata  (len_wdata)
    );

    psrq_store #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .SLOT_BYTES  (SLOT_BYTES)
    ) u_store (
        .i_clk        (i_clk),
        .i_rd_en      (rd_en),
        .i_byte_raddr (byte_raddr),
        .i_len_raddr  (len_raddr),
        .o_byte_rdata (byte_rdata),
        .o_len_rdata  (len_rdata),
        .i_byte_we    (byte_we),
        .i_byte_waddr (byte_waddr),
        .i_byte_wdata (byte_wdata),
        .i_len_we     (len_we),
        .i_len_waddr  (len_waddr),
        .i_len_wdata  (len_wdata)
    );

    psrq_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_skid_busy (skid_busy),
        .o_rsp       (o_rsp)
    );

endmodule
`default_nettype wire
